// File: hdl/min_weight_polygon_triangulation_top_macros.svh
// ----------------------------------------------------------------------------
// min_weight_polygon_triangulation_top_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MIN_WEIGHT_POLYGON_TRIANGULATION_TOP_MACROS_SVH
`define MIN_WEIGHT_POLYGON_TRIANGULATION_TOP_MACROS_SVH

// condition implies property in the same cycle
`define MWPT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// condition implies property in the next cycle
`define MWPT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: hdl/mwpt_pkg.sv
// ----------------------------------------------------------------------------
// mwpt_pkg
// types, constants and helpers of the polygon triangulation block
// ----------------------------------------------------------------------------
package mwpt_pkg;

    localparam int COORD_W     = 16;
    localparam int COST_W      = 30;
    localparam int OUT_IDX_W   = 5;
    localparam int MAX_RESULTS = 29;
    localparam logic [COST_W-1:0] COST_MAX = 30'h3FFF_FFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } t_in_item;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] from_vertex;
        logic [OUT_IDX_W-1:0] to_vertex;
        logic                 has_diagonal;
        logic [COST_W-1:0]    total_cost;
        logic                 last_result;
    } t_out_item;

    typedef struct packed {
        logic vtx_we;
        logic dist_abs;
        logic dist_sq;
        logic dist_start;
        logic dist_step;
        logic dist_we;
        logic dp_sum;
        logic dp_cmp;
        logic dp_first;
        logic dp_we;
        logic use_ck;
        logic use_cl;
        logic use_dki;
        logic use_dil;
        logic stk_we;
        logic out_load;
        logic out_has;
        logic out_last;
        logic out_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic sqrt_done;
    } t_dp_status;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

// File: hdl/mwpt_ram.sv
// ----------------------------------------------------------------------------
// mwpt_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mwpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hdl/mwpt_dp.sv
// ----------------------------------------------------------------------------
// mwpt_dp
// datapath: vertex store, distance unit with iterative root, cost tables,
// split compare, walk stack and output register
// ----------------------------------------------------------------------------
module mwpt_dp #(
    parameter int MAX_VERTICES = 32,
    parameter int FRAC_BITS    = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  mwpt_pkg::t_dp_cmd                       i_cmd,
    output mwpt_pkg::t_dp_status                    o_status,
    input  mwpt_pkg::t_in_item                      i_in_data,
    input  logic [$clog2(MAX_VERTICES)-1:0]         i_idx_a,
    input  logic [$clog2(MAX_VERTICES)-1:0]         i_idx_b,
    input  logic [$clog2(MAX_VERTICES)-1:0]         i_idx_c,
    input  logic [$clog2(MAX_VERTICES)-1:0]         i_from,
    input  logic [$clog2(MAX_VERTICES)-1:0]         i_to,
    input  logic [$clog2(2*MAX_VERTICES)-1:0]       i_stk_waddr,
    input  logic [$clog2(2*MAX_VERTICES)-1:0]       i_stk_raddr,
    input  logic [2*$clog2(MAX_VERTICES):0]         i_stk_wdata,
    output logic [2*$clog2(MAX_VERTICES):0]         o_stk_rdata,
    output logic [$clog2(MAX_VERTICES)-1:0]         o_split,
    output mwpt_pkg::t_out_item                     o_out_data
);
    import mwpt_pkg::*;

    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int VD  = 1 << IW;
    localparam int TD  = 1 << (2 * IW);
    localparam int SD  = 2 * MAX_VERTICES;
    localparam int SEW = 2 * IW + 1;
    localparam int RW  = 17 + FRAC_BITS;
    localparam int NIT = 17 + FRAC_BITS;
    localparam int NCW = $clog2(NIT + 1);

    logic [2*COORD_W-1:0] vtx_a;
    logic [2*COORD_W-1:0] vtx_b;
    logic [COST_W-1:0]    cost_ki;
    logic [COST_W-1:0]    cost_il;
    logic [COST_W-1:0]    dist_ki;
    logic [COST_W-1:0]    dist_il;
    logic [IW-1:0]        split_b;
    logic [SEW-1:0]       stk_b;

    logic [15:0]     r_ax;
    logic [15:0]     r_ay;
    logic [31:0]     r_sx;
    logic [31:0]     r_sy;
    logic [33:0]     r_d2;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [NCW-1:0]  r_scnt;
    logic [COST_W-1:0] r_sa;
    logic [COST_W-1:0] r_sb;
    logic [COST_W-1:0] r_best;
    logic [IW-1:0]   r_bi;
    logic [COST_W-1:0] r_total;
    t_out_item       r_out;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic [RW+29:0]  root_w;
    logic [COST_W-1:0] root_sat;
    logic [COST_W-1:0] cand;
    logic [IW+4:0]   from_w;
    logic [IW+4:0]   to_w;

    mwpt_ram #(.WIDTH(2*COORD_W), .DEPTH(VD)) u_vtx (
        .i_clk(i_clk), .i_we(i_cmd.vtx_we), .i_waddr(i_idx_a),
        .i_wdata({i_in_data.vertex_x, i_in_data.vertex_y}),
        .i_raddr_a(i_idx_a), .i_raddr_b(i_idx_b),
        .o_rdata_a(vtx_a), .o_rdata_b(vtx_b)
    );

    mwpt_ram #(.WIDTH(COST_W), .DEPTH(TD)) u_dist (
        .i_clk(i_clk), .i_we(i_cmd.dist_we), .i_waddr({i_idx_a, i_idx_b}),
        .i_wdata(root_sat),
        .i_raddr_a({i_idx_a, i_idx_c}), .i_raddr_b({i_idx_c, i_idx_b}),
        .o_rdata_a(dist_ki), .o_rdata_b(dist_il)
    );

    mwpt_ram #(.WIDTH(COST_W), .DEPTH(TD)) u_cost (
        .i_clk(i_clk), .i_we(i_cmd.dp_we), .i_waddr({i_idx_a, i_idx_b}),
        .i_wdata(r_best),
        .i_raddr_a({i_idx_a, i_idx_c}), .i_raddr_b({i_idx_c, i_idx_b}),
        .o_rdata_a(cost_ki), .o_rdata_b(cost_il)
    );

    mwpt_ram #(.WIDTH(IW), .DEPTH(TD)) u_split (
        .i_clk(i_clk), .i_we(i_cmd.dp_we), .i_waddr({i_idx_a, i_idx_b}),
        .i_wdata(r_bi),
        .i_raddr_a({i_idx_a, i_idx_b}), .i_raddr_b({i_idx_a, i_idx_b}),
        .o_rdata_a(o_split), .o_rdata_b(split_b)
    );

    mwpt_ram #(.WIDTH(SEW), .DEPTH(SD)) u_stack (
        .i_clk(i_clk), .i_we(i_cmd.stk_we), .i_waddr(i_stk_waddr),
        .i_wdata(i_stk_wdata),
        .i_raddr_a(i_stk_raddr), .i_raddr_b(i_stk_raddr),
        .o_rdata_a(o_stk_rdata), .o_rdata_b(stk_b)
    );

    always_comb begin
        dx       = (COORD_W+1)'($signed(vtx_a[31:16])) - (COORD_W+1)'($signed(vtx_b[31:16]));
        dy       = (COORD_W+1)'($signed(vtx_a[15:0])) - (COORD_W+1)'($signed(vtx_b[15:0]));
        rem_sh   = {r_rem[RW-1:0], r_d2[33:32]};
        trial    = {r_root, 2'b01};
        root_w   = (RW+30)'(r_root);
        root_sat = (root_w > (RW+30)'(COST_MAX)) ? COST_MAX : root_w[COST_W-1:0];
        cand     = sat_add(r_sa, r_sb);
        from_w   = (IW+5)'(i_from);
        to_w     = (IW+5)'(i_to);
    end

    assign o_status.sqrt_done = (r_scnt == NCW'(NIT));
    assign o_out_data         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt <= '0;
        end else if (i_cmd.dist_start) begin
            r_scnt <= '0;
        end else if (i_cmd.dist_step) begin
            r_scnt <= r_scnt + NCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dist_abs) begin
            r_ax <= dx[COORD_W] ? 16'(-dx) : dx[15:0];
            r_ay <= dy[COORD_W] ? 16'(-dy) : dy[15:0];
        end
        if (i_cmd.dist_sq) begin
            r_sx <= r_ax * r_ax;
            r_sy <= r_ay * r_ay;
        end
        if (i_cmd.dist_start) begin
            r_d2   <= {1'b0, 33'(r_sx) + 33'(r_sy)};
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.dist_step) begin
            r_d2 <= {r_d2[31:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
        if (i_cmd.dp_sum) begin
            r_sa <= sat_add(i_cmd.use_ck ? cost_ki : '0, i_cmd.use_cl ? cost_il : '0);
            r_sb <= sat_add(i_cmd.use_dki ? dist_ki : '0, i_cmd.use_dil ? dist_il : '0);
        end
        if (i_cmd.dp_cmp) begin
            if (i_cmd.dp_first || r_best >= cand) begin
                r_best <= cand;
                r_bi   <= i_idx_c;
            end
        end
        if (i_cmd.dp_we) begin
            r_total <= r_best;
        end
        if (i_cmd.out_load) begin
            r_out.from_vertex  <= from_w[OUT_IDX_W-1:0];
            r_out.to_vertex    <= to_w[OUT_IDX_W-1:0];
            r_out.has_diagonal <= i_cmd.out_has;
            r_out.total_cost   <= i_cmd.out_zero ? '0 : r_total;
            r_out.last_result  <= i_cmd.out_last;
        end
    end

endmodule

// File: hdl/mwpt_ctrl.sv
// ----------------------------------------------------------------------------
// mwpt_ctrl
// controller: vertex loading, distance sweep, interval sweep and result walk
// ----------------------------------------------------------------------------
module mwpt_ctrl #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_last_vertex,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mwpt_pkg::t_dp_cmd                 o_cmd,
    input  mwpt_pkg::t_dp_status              i_status,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_idx_a,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_idx_b,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_idx_c,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_from,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_to,
    output logic [$clog2(2*MAX_VERTICES)-1:0] o_stk_waddr,
    output logic [$clog2(2*MAX_VERTICES)-1:0] o_stk_raddr,
    output logic [2*$clog2(MAX_VERTICES):0]   o_stk_wdata,
    input  logic [2*$clog2(MAX_VERTICES):0]   i_stk_rdata,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_split
);
    import mwpt_pkg::*;

    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int XW  = CW + 1;
    localparam int SD  = 2 * MAX_VERTICES;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    typedef enum logic [4:0] {
        S_LOAD, S_SMALL, S_OUT,
        D_RD, D_ABS, D_SQ, D_SUM, D_ROOT, D_WR,
        P_RD, P_SUM, P_CMP, P_WR,
        E_INIT, E_POP, E_WAIT, E_DEC, E_EMIT2, E_PUSH1, E_PUSH2
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [CW-1:0]  r_n, n_n;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_t, n_t;
    logic [IW-1:0]  r_k, n_k;
    logic [IW-1:0]  r_l, n_l;
    logic [IW-1:0]  r_i, n_i;
    logic           r_vis, n_vis;
    logic [SPW-1:0] r_sp, n_sp;
    logic [4:0]     r_ecnt, n_ecnt;
    logic [4:0]     r_lim, n_lim;
    logic           r_out_valid, n_out_valid;

    logic [IW-1:0]  stk_k;
    logic [IW-1:0]  stk_l;
    logic           last_out;

    assign stk_k       = i_stk_rdata[IW-1:0];
    assign stk_l       = i_stk_rdata[2*IW-1:IW];
    assign last_out    = (r_ecnt + 5'd1 == r_lim);
    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_stk_raddr = SAW'(r_sp - SPW'(1));
    assign o_idx_c     = r_i;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_t         = r_t;
        n_k         = r_k;
        n_l         = r_l;
        n_i         = r_i;
        n_vis       = r_vis;
        n_sp        = r_sp;
        n_ecnt      = r_ecnt;
        n_lim       = r_lim;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_idx_a     = r_k;
        o_idx_b     = r_l;
        o_from      = '0;
        o_to        = '0;
        o_stk_waddr = SAW'(r_sp);
        o_stk_wdata = '0;

        unique case (r_state)
            S_LOAD: begin
                o_idx_a = r_cnt[IW-1:0];
                if (i_in_valid) begin
                    if (r_cnt < CW'(MAX_VERTICES)) begin
                        o_cmd.vtx_we = 1'b1;
                        n_cnt        = r_cnt + CW'(1);
                    end
                    if (i_last_vertex) begin
                        n_n   = (r_cnt < CW'(MAX_VERTICES)) ? r_cnt + CW'(1) : r_cnt;
                        n_cnt = '0;
                        if (8'(n_n) > 8'(MAX_RESULTS + 3)) begin
                            n_lim = 5'(MAX_RESULTS);
                        end else begin
                            n_lim = 5'(n_n - CW'(3));
                        end
                        if (n_n < CW'(4)) begin
                            n_state = S_SMALL;
                        end else begin
                            n_k     = '0;
                            n_l     = IW'(2);
                            n_state = D_RD;
                        end
                    end
                end
            end
            S_SMALL: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_zero = 1'b1;
                o_cmd.out_last = 1'b1;
                n_out_valid    = 1'b1;
                n_ret          = S_LOAD;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = r_ret;
                end
            end
            D_RD:  n_state = D_ABS;
            D_ABS: begin
                o_cmd.dist_abs = 1'b1;
                n_state        = D_SQ;
            end
            D_SQ: begin
                o_cmd.dist_sq = 1'b1;
                n_state       = D_SUM;
            end
            D_SUM: begin
                o_cmd.dist_start = 1'b1;
                n_state          = D_ROOT;
            end
            D_ROOT: begin
                if (i_status.sqrt_done) begin
                    n_state = D_WR;
                end else begin
                    o_cmd.dist_step = 1'b1;
                end
            end
            D_WR: begin
                o_cmd.dist_we = 1'b1;
                if (XW'(r_l) + XW'(1) < XW'(r_n)) begin
                    n_l     = r_l + IW'(1);
                    n_state = D_RD;
                end else if (XW'(r_k) + XW'(4) <= XW'(r_n)) begin
                    n_k     = r_k + IW'(1);
                    n_l     = r_k + IW'(3);
                    n_state = D_RD;
                end else begin
                    n_t     = CW'(3);
                    n_k     = '0;
                    n_l     = IW'(3);
                    n_i     = IW'(1);
                    n_state = P_RD;
                end
            end
            P_RD: n_state = P_SUM;
            P_SUM: begin
                o_cmd.dp_sum  = 1'b1;
                o_cmd.use_ck  = (r_i - r_k >= IW'(3));
                o_cmd.use_cl  = (r_l - r_i >= IW'(3));
                o_cmd.use_dki = (r_i != r_k + IW'(1));
                o_cmd.use_dil = (r_i != r_l - IW'(1));
                n_state       = P_CMP;
            end
            P_CMP: begin
                o_cmd.dp_cmp   = 1'b1;
                o_cmd.dp_first = (r_i == r_k + IW'(1));
                if (r_i + IW'(1) < r_l) begin
                    n_i     = r_i + IW'(1);
                    n_state = P_RD;
                end else begin
                    n_state = P_WR;
                end
            end
            P_WR: begin
                o_cmd.dp_we = 1'b1;
                if (XW'(r_l) + XW'(1) < XW'(r_n)) begin
                    n_k     = r_k + IW'(1);
                    n_l     = r_l + IW'(1);
                    n_i     = r_k + IW'(2);
                    n_state = P_RD;
                end else if (r_t + CW'(1) < r_n) begin
                    n_t     = r_t + CW'(1);
                    n_k     = '0;
                    n_l     = IW'(r_t + CW'(1));
                    n_i     = IW'(1);
                    n_state = P_RD;
                end else begin
                    n_state = E_INIT;
                end
            end
            E_INIT: begin
                o_cmd.stk_we = 1'b1;
                o_stk_waddr  = '0;
                o_stk_wdata  = {1'b0, IW'(r_n - CW'(1)), IW'(0)};
                n_sp         = SPW'(1);
                n_ecnt       = '0;
                n_state      = E_POP;
            end
            E_POP: begin
                if (r_sp == '0) begin
                    n_state = S_LOAD;
                end else begin
                    n_sp    = r_sp - SPW'(1);
                    n_state = E_WAIT;
                end
            end
            E_WAIT: begin
                o_idx_a = stk_k;
                o_idx_b = stk_l;
                n_k     = stk_k;
                n_l     = stk_l;
                n_vis   = i_stk_rdata[2*IW];
                n_state = E_DEC;
            end
            E_DEC: begin
                n_i = i_split;
                if (r_vis) begin
                    if (i_split != r_k + IW'(1)) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_has  = 1'b1;
                        o_cmd.out_last = last_out;
                        o_from         = r_k;
                        o_to           = i_split;
                        n_ecnt         = r_ecnt + 5'd1;
                        n_out_valid    = 1'b1;
                        n_ret          = last_out ? S_LOAD : E_EMIT2;
                        n_state        = S_OUT;
                    end else begin
                        n_state = E_EMIT2;
                    end
                end else begin
                    o_cmd.stk_we = 1'b1;
                    o_stk_wdata  = {1'b1, r_l, r_k};
                    n_sp         = r_sp + SPW'(1);
                    n_state      = E_PUSH1;
                end
            end
            E_EMIT2: begin
                if (r_i != r_l - IW'(1)) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_has  = 1'b1;
                    o_cmd.out_last = last_out;
                    o_from         = r_i;
                    o_to           = r_l;
                    n_ecnt         = r_ecnt + 5'd1;
                    n_out_valid    = 1'b1;
                    n_ret          = last_out ? S_LOAD : E_POP;
                    n_state        = S_OUT;
                end else begin
                    n_state = E_POP;
                end
            end
            E_PUSH1: begin
                if (r_l - r_i >= IW'(3)) begin
                    o_cmd.stk_we = 1'b1;
                    o_stk_wdata  = {1'b0, r_l, r_i};
                    n_sp         = r_sp + SPW'(1);
                end
                n_state = E_PUSH2;
            end
            E_PUSH2: begin
                if (r_i - r_k >= IW'(3)) begin
                    o_cmd.stk_we = 1'b1;
                    o_stk_wdata  = {1'b0, r_i, r_k};
                    n_sp         = r_sp + SPW'(1);
                end
                n_state = E_POP;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ret       <= S_LOAD;
            r_n         <= '0;
            r_cnt       <= '0;
            r_t         <= '0;
            r_k         <= '0;
            r_l         <= '0;
            r_i         <= '0;
            r_vis       <= 1'b0;
            r_sp        <= '0;
            r_ecnt      <= '0;
            r_lim       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_n         <= n_n;
            r_cnt       <= n_cnt;
            r_t         <= n_t;
            r_k         <= n_k;
            r_l         <= n_l;
            r_i         <= n_i;
            r_vis       <= n_vis;
            r_sp        <= n_sp;
            r_ecnt      <= n_ecnt;
            r_lim       <= n_lim;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/min_weight_polygon_triangulation_top.sv
// operation: vertices are taken while the block loads; after the last vertex it computes the
// diagonal lengths (one root bit a cycle), then evaluates each split (about n^3/6 of them) in
// read, sum and compare steps plus a table write per sub-polygon, then walks the stack to emit
// each diagonal result, which is held until the receiver takes it
// throughput: one polygon at a time; the distance sweep and the split loop take most of its time
// reset: synchronous active low, clears the controller; tables undefined until written
// ----------------------------------------------------------------------------
// min_weight_polygon_triangulation_top
// minimum weight triangulation of a convex polygon
// ----------------------------------------------------------------------------
module min_weight_polygon_triangulation_top #(
    parameter int MAX_VERTICES = 32,
    parameter int FRAC_BITS    = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mwpt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mwpt_pkg::t_out_item o_out_data
);
    import mwpt_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);

    t_dp_cmd                      cmd;
    t_dp_status                   status;
    logic [IW-1:0]                idx_a;
    logic [IW-1:0]                idx_b;
    logic [IW-1:0]                idx_c;
    logic [IW-1:0]                from_idx;
    logic [IW-1:0]                to_idx;
    logic [$clog2(2*MAX_VERTICES)-1:0] stk_waddr;
    logic [$clog2(2*MAX_VERTICES)-1:0] stk_raddr;
    logic [2*IW:0]                stk_wdata;
    logic [2*IW:0]                stk_rdata;
    logic [IW-1:0]                split;

    mwpt_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_last_vertex(i_in_data.last_vertex),
        .o_in_ready(o_in_ready), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_cmd(cmd), .i_status(status),
        .o_idx_a(idx_a), .o_idx_b(idx_b), .o_idx_c(idx_c),
        .o_from(from_idx), .o_to(to_idx),
        .o_stk_waddr(stk_waddr), .o_stk_raddr(stk_raddr), .o_stk_wdata(stk_wdata),
        .i_stk_rdata(stk_rdata), .i_split(split)
    );

    mwpt_dp #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status), .i_in_data(i_in_data),
        .i_idx_a(idx_a), .i_idx_b(idx_b), .i_idx_c(idx_c),
        .i_from(from_idx), .i_to(to_idx),
        .i_stk_waddr(stk_waddr), .i_stk_raddr(stk_raddr), .i_stk_wdata(stk_wdata),
        .o_stk_rdata(stk_rdata), .o_split(split), .o_out_data(o_out_data)
    );

endmodule

// File: hdl/mwpt_checker.sv
// ----------------------------------------------------------------------------
// mwpt_checker
// port level checks of the triangulation block
// ----------------------------------------------------------------------------
`include "min_weight_polygon_triangulation_top_macros.svh"

module mwpt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input mwpt_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mwpt_pkg::t_out_item o_out_data
);
    import mwpt_pkg::*;

    // result held until taken
    `MWPT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    // no vertex taken while a result waits
    `MWPT_ASSERT_NOW(a_excl, o_in_ready, !o_out_valid)
    // closing vertex starts the computation
    `MWPT_ASSERT_NEXT(a_close, i_in_valid && o_in_ready && i_in_data.last_vertex, !o_in_ready)
    // after the final result the block loads again
    `MWPT_ASSERT_NEXT(a_done, o_out_valid && i_out_ready && o_out_data.last_result,
                      o_in_ready && !o_out_valid)

endmodule

bind min_weight_polygon_triangulation_top mwpt_checker u_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the polygon triangulation block: vertices are streamed in as
// polygons, each result request is compared with a local prediction of the
// minimum weight triangulation, under random stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;
    import mwpt_pkg::*;

    localparam int MAXV = 32;
    localparam int FRAC = 8;
    localparam int WATCHDOG_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    min_weight_polygon_triangulation_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // prediction state
    int        poly_x[MAXV];
    int        poly_y[MAXV];
    int        poly_len;
    bit [29:0] sub_cost[MAXV][MAXV];
    int        sub_split[MAXV][MAXV];
    int        walk_n;

    t_in_item  vertex_queue[$];
    t_out_item diag_queue[$];

    int  mismatches;
    int  watchdog;
    bit  in_taken;
    bit  hold_off_req;
    bit  pause_sender;
    int  hold_off_left;
    int  gap_left;
    int  stall_left;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic bit [29:0] add_sat(bit [29:0] a, bit [29:0] b);
        bit [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[30] ? 30'h3FFF_FFFF : s[29:0];
    endfunction

    function automatic bit [29:0] edge_length(int a, int b);
        longint    dx;
        longint    dy;
        bit [63:0] d2;
        bit [63:0] rem;
        bit [63:0] root;
        bit [63:0] trial;
        bit [63:0] pair;
        dx = poly_x[a] - poly_x[b];
        dy = poly_y[a] - poly_y[b];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        d2 = dx * dx + dy * dy;
        rem = 0;
        root = 0;
        for (int n = 0; n < 17 + FRAC; n++) begin
            pair = (n < 17) ? ((d2 >> (2 * (16 - n))) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return (root > 64'h3FFF_FFFF) ? 30'h3FFF_FFFF : root[29:0];
    endfunction

    function automatic void push_diag(int a, int b, bit [29:0] cost);
        t_out_item r;
        r.from_vertex  = a[4:0];
        r.to_vertex    = b[4:0];
        r.has_diagonal = 1'b1;
        r.total_cost   = cost;
        r.last_result  = 1'b0;
        diag_queue.insert(diag_queue.size(), r);
        walk_n++;
    endfunction

    function automatic void emit_diagonals(int k, int l, bit [29:0] cost);
        int i;
        i = sub_split[k][l];
        if (i - k >= 3) emit_diagonals(k, i, cost);
        if (l - i >= 3) emit_diagonals(i, l, cost);
        if (i != k + 1 && walk_n < MAX_RESULTS) push_diag(k, i, cost);
        if (i != l - 1 && walk_n < MAX_RESULTS) push_diag(i, l, cost);
    endfunction

    function automatic void triangulate_vertex(t_in_item v);
        int        n;
        int        l;
        bit [29:0] best;
        bit [29:0] c;
        t_out_item r;
        if (poly_len < MAXV) begin
            poly_x[poly_len] = int'(v.vertex_x);
            poly_y[poly_len] = int'(v.vertex_y);
            poly_len++;
        end
        if (!v.last_vertex) return;
        n = poly_len;
        poly_len = 0;
        if (n < 4) begin
            r = '0;
            r.last_result = 1'b1;
            diag_queue.insert(diag_queue.size(), r);
            return;
        end
        for (int t = 3; t < n; t++) begin
            for (int k = 0; k + t < n; k++) begin
                l = k + t;
                best = 0;
                sub_split[k][l] = k + 1;
                for (int i = k + 1; i < l; i++) begin
                    c = 0;
                    if (i - k >= 3) c = add_sat(c, sub_cost[k][i]);
                    if (l - i >= 3) c = add_sat(c, sub_cost[i][l]);
                    if (i != k + 1) c = add_sat(c, edge_length(k, i));
                    if (i != l - 1) c = add_sat(c, edge_length(i, l));
                    if (i == k + 1 || best >= c) begin
                        best = c;
                        sub_split[k][l] = i;
                    end
                end
                sub_cost[k][l] = best;
            end
        end
        walk_n = 0;
        emit_diagonals(0, n - 1, sub_cost[0][n - 1]);
        if (walk_n > 0) diag_queue[$].last_result = 1'b1;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            i_in_valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_in_valid <= 1'b0;
        end else if (vertex_queue.size() > 0 && !pause_sender) begin
            i_in_valid <= 1'b1;
            i_in_data  <= vertex_queue.pop_front();
            gap_left   <= pick_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_off_req && o_out_valid) begin
            hold_off_req  <= 1'b0;
            hold_off_left <= 3000;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            in_taken <= i_in_valid && o_in_ready;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                watchdog <= 0;
            end else begin
                watchdog <= watchdog + 1;
            end
            if (i_in_valid && o_in_ready) begin
                triangulate_vertex(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                if (diag_queue.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, o_out_data);
                    mismatches++;
                end else begin
                    want = diag_queue.pop_front();
                    if (o_out_data !== want) begin
                        $display("%0t: expected %p, actual %p", $time, want, o_out_data);
                        mismatches++;
                    end
                end
            end
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    task automatic add_vertex(int x, int y, bit last);
        t_in_item v;
        v.vertex_x = x[15:0];
        v.vertex_y = y[15:0];
        v.last_vertex = last;
        vertex_queue.insert(vertex_queue.size(), v);
    endtask

    task automatic add_polygon(int n, int span);
        int cx;
        int cy;
        int r;
        real a;
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        r = $urandom_range(1, span);
        for (int j = 0; j < n; j++) begin
            a = 6.2831853 * j / n;
            add_vertex(cx + int'(r * $cos(a)), cy + int'(r * $sin(a)), j == n - 1);
        end
    endtask

    task automatic wait_drained();
        while (vertex_queue.size() > 0 || i_in_valid || diag_queue.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int n;
        mismatches = 0;
        watchdog = 0;
        poly_len = 0;
        gap_left = 0;
        stall_left = 0;
        hold_off_left = 0;
        hold_off_req = 1'b0;
        pause_sender = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_in_data = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: tiny polygons, extreme coordinates, square ties
        add_vertex(5, 5, 1);
        add_vertex(-32768, -32768, 0);
        add_vertex(32767, 32767, 1);
        add_vertex(-32768, 32767, 0);
        add_vertex(32767, -32768, 0);
        add_vertex(0, 0, 1);
        add_vertex(-32768, -32768, 0);
        add_vertex(32767, -32768, 0);
        add_vertex(32767, 32767, 0);
        add_vertex(-32768, 32767, 1);
        add_vertex(0, 0, 0);
        add_vertex(10, 0, 0);
        add_vertex(10, 10, 0);
        add_vertex(0, 10, 1);
        add_vertex(0, 0, 0);
        add_vertex(0, 0, 0);
        add_vertex(0, 0, 0);
        add_vertex(0, 0, 0);
        add_vertex(0, 0, 1);
        wait_drained();

        // store overflow: 34 vertices, the last two dropped
        add_polygon(34, 30000);
        hold_off_req = 1'b1;
        add_polygon(12, 100);
        wait_drained();
        pause_sender = 1'b1;
        repeat (50) @(posedge i_clk);
        pause_sender = 1'b0;

        n = 0;
        while (n < 300) begin
            int sz;
            if ($urandom_range(0, 9) == 0) begin
                sz = $urandom_range(1, 3);
                for (int j = 0; j < sz; j++)
                    add_vertex($urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768, j == sz - 1);
            end else begin
                sz = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 32)
                                                  : $urandom_range(4, 9);
                add_polygon(sz, ($urandom_range(0, 3) == 0) ? 32767 : 2000);
            end
            n += sz;
            if ($urandom_range(0, 15) == 0) wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
